FILE: hw/rtl/lfc_pkg.sv
// Shared constants for the LRU/FIFO replacement cache.
`timescale 1ns / 1ps
package lfc_pkg;

  // Fixed field widths of the ports
  localparam int IN_KEY_W  = 16;
  localparam int MISS_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 1'd1;

  // Replacement policy codes
  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_FIFO = 1'b1;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

endpackage

FILE: hw/rtl/lfc_entry_ram.sv
// Single-port-read, single-port-write entry memory with registered read data.
`timescale 1ns / 1ps
module lfc_entry_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/lru_fifo_cache_replacement.sv
// Top level: fully associative key cache with LRU or FIFO replacement.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low. Busy stays high
// while a request sweeps the entries, so a new request is taken only once
// the previous one is done. Its result appears on the out_ ports with out_valid
// high for one cycle; the receiver cannot stall it, so capture it then.
// The entry memory has a single read port, so the request sweeps it one
// way per cycle: each sweep finds the match, the oldest entry and the first
// free way, and applies the age and key update left by the previous request.
// Valid bits sit in flip-flops, so no clearing pass follows reset.
// Configuration writes are taken at any edge but belong between requests.
module lru_fifo_cache_replacement #(
  parameter int WAYS     = 16,
  parameter int KEY_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [lfc_pkg::IN_KEY_W-1:0]    in_request_key,
  output logic                            out_valid,
  output logic                            out_hit,
  output logic [lfc_pkg::MISS_W-1:0]      out_miss_count,
  output logic                            out_victim_valid,
  output logic [lfc_pkg::IN_KEY_W-1:0]    out_victim_key,
  input  logic                            cfg_we,
  input  logic [lfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lfc_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import lfc_pkg::*;

  localparam int IDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(WAYS + 1);
  localparam int LIM_W  = RANK_W + 1;
  localparam int ENT_W  = KEY_BITS + RANK_W;
  localparam logic [LIM_W-1:0] LIM_ALL  = LIM_W'(WAYS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WAYS);

  logic [1:0]            state_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [KEY_BITS-1:0]   key_r;

  logic [CFG_DAT_W-1:0]  cap_r;
  logic                  policy_r;

  logic [WAYS-1:0]       valid_r;
  logic [CNT_W-1:0]      fill_r;
  logic [MISS_W-1:0]     miss_r;

  // update owed to the memory by the previous request
  logic                  pend_en_r;
  logic [IDX_W-1:0]      pend_way_r;
  logic [LIM_W-1:0]      pend_lim_r;
  logic                  pend_wkey_r;
  logic [KEY_BITS-1:0]   pend_key_r;

  // read pipeline tag
  logic                  chk_vld_r;
  logic [IDX_W-1:0]      chk_way_r;

  // sweep results
  logic                  found_r;
  logic [IDX_W-1:0]      found_way_r;
  logic [RANK_W-1:0]     found_rank_r;
  logic                  free_found_r;
  logic [IDX_W-1:0]      free_way_r;
  logic                  old_found_r;
  logic [IDX_W-1:0]      old_way_r;
  logic [RANK_W-1:0]     old_rank_r;
  logic [KEY_BITS-1:0]   old_key_r;

  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [MISS_W-1:0]     out_miss_r;
  logic                  out_vv_r;
  logic [IN_KEY_W-1:0]   out_vkey_r;

  logic                  rd_issue;
  logic [ENT_W-1:0]      rd_data;
  logic [KEY_BITS-1:0]   rd_key;
  logic [RANK_W-1:0]     rd_rank;
  logic                  chk_valid;
  logic                  is_pway;
  logic [KEY_BITS-1:0]   upd_key;
  logic [RANK_W-1:0]     upd_rank;
  logic                  wr_en;
  logic [CNT_W-1:0]      cap_eff;
  logic                  accept;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign rd_issue = (state_r == ST_SCAN) && (cnt_r != CNT_LAST);

  lfc_entry_ram #(
    .WIDTH (ENT_W),
    .DEPTH (WAYS)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_issue),
    .rd_addr (cnt_r[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (chk_way_r),
    .wr_data ({upd_key, upd_rank})
  );

  // Apply the pending update to the entry just read.
  always_comb begin
    rd_key    = rd_data[ENT_W-1:RANK_W];
    rd_rank   = rd_data[RANK_W-1:0];
    chk_valid = valid_r[chk_way_r];
    is_pway   = pend_en_r && (chk_way_r == pend_way_r);
    upd_key   = (is_pway && pend_wkey_r) ? pend_key_r : rd_key;
    if (is_pway) begin
      upd_rank = '0;
    end else if (pend_en_r && chk_valid && ({1'b0, rd_rank} < pend_lim_r)) begin
      upd_rank = rd_rank + RANK_W'(1);
    end else begin
      upd_rank = rd_rank;
    end
    wr_en = chk_vld_r && pend_en_r && chk_valid;
  end

  // clamp capacity into 1..WAYS
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_r) > WAYS) begin
      cap_eff = CNT_LAST;
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CFG_DAT_W'(16);
      policy_r <= POLICY_LRU;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAPACITY: cap_r    <= cfg_data;
        REG_POLICY:   policy_r <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      valid_r     <= '0;
      fill_r      <= '0;
      miss_r      <= '0;
      pend_en_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      chk_vld_r   <= rd_issue;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_SCAN;
            cnt_r   <= '0;
          end
        end
        ST_SCAN: begin
          if (rd_issue) begin
            cnt_r <= cnt_r + CNT_W'(1);
          end else begin
            // last entry is being checked this cycle
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b1;
          if (found_r) begin
            pend_en_r <= (policy_r == POLICY_LRU);
          end else begin
            pend_en_r <= 1'b1;
            if (miss_r != '1) begin
              miss_r <= miss_r + MISS_W'(1);
            end
            if ((fill_r < cap_eff) && free_found_r) begin
              valid_r[free_way_r] <= 1'b1;
              fill_r <= fill_r + CNT_W'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // payload: request key, sweep trackers, pending update, result
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r        <= KEY_BITS'(in_request_key);
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      old_found_r  <= 1'b0;
    end
    if (chk_vld_r) begin
      if (chk_valid) begin
        if (!found_r && (upd_key == key_r)) begin
          found_r      <= 1'b1;
          found_way_r  <= chk_way_r;
          found_rank_r <= upd_rank;
        end
        if (!old_found_r || (upd_rank > old_rank_r)) begin
          old_found_r <= 1'b1;
          old_way_r   <= chk_way_r;
          old_rank_r  <= upd_rank;
          old_key_r   <= upd_key;
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
        free_way_r   <= chk_way_r;
      end
    end
    chk_way_r <= cnt_r[IDX_W-1:0];
    if (state_r == ST_DONE) begin
      out_hit_r <= found_r;
      out_vv_r  <= 1'b0;
      out_vkey_r <= '0;
      if (found_r) begin
        out_miss_r  <= miss_r;
        pend_way_r  <= found_way_r;
        pend_lim_r  <= {1'b0, found_rank_r};
        pend_wkey_r <= 1'b0;
      end else begin
        out_miss_r  <= (miss_r != '1) ? miss_r + MISS_W'(1) : miss_r;
        pend_wkey_r <= 1'b1;
        pend_key_r  <= key_r;
        if ((fill_r < cap_eff) && free_found_r) begin
          pend_way_r <= free_way_r;
          pend_lim_r <= LIM_ALL;
        end else begin
          // evict the oldest entry and reuse its way
          pend_way_r <= old_way_r;
          pend_lim_r <= {1'b0, old_rank_r};
          out_vv_r   <= old_found_r;
          out_vkey_r <= old_found_r ? IN_KEY_W'(old_key_r) : '0;
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_miss_count   = out_miss_r;
  assign out_victim_valid = out_vv_r;
  assign out_victim_key   = out_vkey_r;

endmodule
